FILE: rtl/hkst_pkg.sv
// Shared constants, command codes and control types for the hashed key set table.
package hkst_pkg;

  // Table geometry. BUCKETS must be a power of two (bucket = hash low bits).
  localparam int unsigned BUCKETS  = 256;
  localparam int unsigned WAYS     = 4;
  localparam int unsigned BUCKET_W = $clog2(BUCKETS);
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned KEY_W    = 2 * HALF_W;
  localparam int unsigned CMD_W    = 2;

  // Command codes; the unused code behaves as a lookup.
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture input transfer, hash the key
    logic read;    // read the bucket row
    logic commit;  // update the table, load the result register
  } hkst_cmd_t;

endpackage

FILE: rtl/hkst_ctrl.sv
// Controller state machine for the hashed key set table.
module hkst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output hkst_pkg::hkst_cmd_t cmd
);
  import hkst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_CMP  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_busy;

  assign out_busy = out_valid && out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        // hold until the result register is free
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !out_busy)
    else $error("commit while result register still occupied");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> cmd.read)
    else $error("accepted transfer not followed by bucket read");

endmodule

FILE: rtl/hkst_dp.sv
// Datapath: key hash, bucket storage, way compare and result register.
module hkst_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  hkst_pkg::hkst_cmd_t        cmd,
  input  logic [hkst_pkg::CMD_W-1:0]  command,
  input  logic [hkst_pkg::HALF_W-1:0] key_high,
  input  logic [hkst_pkg::HALF_W-1:0] key_low,
  output logic                       was_present,
  output logic                       status
);
  import hkst_pkg::*;

  // sum of the eight bytes of one key half, modulo 256
  function automatic logic [7:0] half_sum(input logic [HALF_W-1:0] v);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < HALF_W / 8; i++) begin
      s = s + v[8*i +: 8];
    end
    return s;
  endfunction

  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [BUCKET_W-1:0] bucket_q;
  logic [7:0]          hash;

  // storage: key rows per way, valid row per bucket, row-written flags
  logic [KEY_W-1:0] key_mem [WAYS][BUCKETS];
  logic [WAYS-1:0]  vld_mem [BUCKETS];
  logic [BUCKETS-1:0] row_init;

  logic [KEY_W-1:0] key_rd [WAYS];
  logic [WAYS-1:0]  vld_rd;

  logic [WAYS-1:0]  match;
  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             has_free;
  logic [WAY_W-1:0] free_way;
  logic             add_ok;
  logic             add_drop;
  logic             rem_ok;
  logic [WAYS-1:0]  vld_new;

  assign hash = half_sum(key_high) + half_sum(key_low);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q    <= command;
      key_q    <= {key_high, key_low};
      bucket_q <= hash[BUCKET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      for (int w = 0; w < WAYS; w++) begin
        key_rd[w] <= key_mem[w][bucket_q];
      end
      vld_rd <= row_init[bucket_q] ? vld_mem[bucket_q] : '0;
    end
  end

  // way compare, lowest match and lowest free way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    has_free = 1'b0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = vld_rd[w] && (key_rd[w] == key_q);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!vld_rd[w]) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  assign add_ok   = (cmd_q == CMD_ADD) && !hit && has_free;
  assign add_drop = (cmd_q == CMD_ADD) && !hit && !has_free;
  assign rem_ok   = (cmd_q == CMD_REMOVE) && hit;

  always_comb begin
    vld_new = vld_rd;
    if (add_ok) begin
      vld_new[free_way] = 1'b1;
    end else if (rem_ok) begin
      vld_new[hit_way] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && add_ok) begin
      key_mem[free_way][bucket_q] <= key_q;
    end
    if (cmd.commit && (add_ok || rem_ok)) begin
      vld_mem[bucket_q] <= vld_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (cmd.commit && (add_ok || rem_ok)) begin
      row_init[bucket_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      was_present <= hit;
      status      <= add_drop;
    end
  end

  a_drop_absent: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && add_drop) |-> (vld_rd == {WAYS{1'b1}}))
    else $error("add dropped with a free way");

  a_one_match: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $onehot0(match))
    else $error("key present in more than one way");

  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && add_ok) |=> row_init[$past(bucket_q)])
    else $error("written row not marked");

endmodule

FILE: rtl/hashed_key_set_table_core.sv
// Top level of the hashed key set table: controller plus datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_stall  | command, key_high, key_low
//  out     | output    | out_valid / out_stall| was_present, status
//
// Each transfer goes through accept and hash, bucket row read, then compare and
// write back; a new transfer is accepted only once the previous one is done.
// Reset clears the controller and the per-row written flags; key storage
// needs no clearing, a row never written reads as all slots empty.
// A stalled result is held in the output register; the block finishes the
// next item's read and waits in compare until that register frees up.
module hashed_key_set_table_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [hkst_pkg::CMD_W-1:0]  command,
  input  logic [hkst_pkg::HALF_W-1:0] key_high,
  input  logic [hkst_pkg::HALF_W-1:0] key_low,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       was_present,
  output logic                       status
);
  import hkst_pkg::*;

  hkst_cmd_t cmd;

  // sequencing: accept, read, commit
  hkst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // hash, storage, compare, result register
  hkst_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .command     (command),
    .key_high    (key_high),
    .key_low     (key_low),
    .was_present (was_present),
    .status      (status)
  );

  a_status_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(status && was_present))
    else $error("dropped add reported as present");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transfer accepted while busy");

  a_out_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_valid) |-> ##3 out_valid)
    else $error("result missing after accepted transfer");

endmodule
